// ===== design/vfsrt_pkg.sv =====
// Shared types, codes and helpers of the vendor-filtered signal-ranked table.
`default_nettype none
package vfsrt_pkg;

  localparam int unsigned TableDepthDef = 128;

  // Reset values of the configuration registers.
  localparam logic [23:0] VendorPrefixRst = 24'h0025DF;
  localparam logic [15:0] MinGapRst       = 16'd50;
  localparam logic [15:0] ReportLimitRst  = 16'd500;
  localparam logic [7:0]  ThinAboveRst    = 8'd80;
  localparam logic [7:0]  EvictCountRst   = 8'd25;

  typedef enum logic [2:0] {
    REG_VENDOR_PREFIX = 3'd0,
    REG_MIN_GAP       = 3'd1,
    REG_REPORT_LIMIT  = 3'd2,
    REG_THIN_ABOVE    = 3'd3,
    REG_EVICT_COUNT   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_REPORT = 2'd0,
    FUNC_RESCAN = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_TOO_SOON   = 4'd0,
    ST_STOP_SCAN  = 4'd1,
    ST_THINNED    = 4'd2,
    ST_WRONG_VEND = 4'd3,
    ST_UPDATED    = 4'd4,
    ST_INSERTED   = 4'd5,
    ST_RESCAN     = 4'd6,
    ST_READ_OK    = 4'd7,
    ST_READ_EMPTY = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_WR,
    S_KEY_RD,
    S_KEY_LD,
    S_SORT_RD,
    S_SORT_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_READ_RD,
    S_READ_OUT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [47:0]        mac;
    logic signed [7:0]  rssi;
    logic [31:0]        seen;
  } entry_t;

  // True when entry a must stand before entry b.
  function automatic logic goes_before(entry_t a, entry_t b, logic by_age);
    logic res;
    if (by_age) begin
      if (a.seen != b.seen) res = (a.seen < b.seen);
      else res = (a.rssi < b.rssi);
    end else begin
      res = (a.rssi > b.rssi);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/vfsrt_mem.sv =====
// Entry memory: one write port, one registered read port.
`default_nettype none
module vfsrt_mem #(
  parameter int unsigned TABLE_DEPTH = vfsrt_pkg::TableDepthDef,
  parameter int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire vfsrt_pkg::entry_t wdata,
  input  wire logic [AW-1:0]     raddr,
  output vfsrt_pkg::entry_t      rdata
);
  import vfsrt_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== design/vfsrt_seq.sv =====
// Sequencer: report filtering, match search, insertion sort, eviction and reads.
`default_nettype none
module vfsrt_seq #(
  parameter int unsigned TABLE_DEPTH = vfsrt_pkg::TableDepthDef,
  parameter int unsigned AW = $clog2(TABLE_DEPTH),
  parameter int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_func,
  input  wire logic [47:0]        in_mac,
  input  wire logic signed [7:0]  in_rssi,
  input  wire logic [31:0]        in_time_ms,
  input  wire logic [6:0]         in_index,
  input  wire logic [23:0]        vendor_prefix,
  input  wire logic [15:0]        min_gap_ms,
  input  wire logic [15:0]        report_limit,
  input  wire logic [7:0]         thin_above,
  input  wire logic [7:0]         evict_count,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output vfsrt_pkg::entry_t       mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  wire vfsrt_pkg::entry_t  mem_rdata,
  output logic                    out_strobe,
  output logic [3:0]              out_status,
  output logic [6:0]              out_rank,
  output logic [7:0]              out_fill,
  output logic [47:0]             out_entry_mac,
  output logic signed [7:0]       out_entry_rssi,
  output logic [31:0]             out_entry_seen
);
  import vfsrt_pkg::*;

  localparam int unsigned XW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   total_r;
  logic [15:0]     counter_r;
  logic [31:0]     last_r;
  func_t           func_r;
  logic [47:0]     mac_r;
  logic signed [7:0] rssi_r;
  logic [31:0]     time_r;
  logic [6:0]      idx_r;
  logic [CW-1:0]   i_r, j_r, track_r, k_r, rest_r;
  entry_t          key_r, ent_r;
  logic            key_trk_r, by_age_r;
  status_t         status_r;
  logic            out_strobe_r;
  logic [3:0]      out_status_r;
  logic [6:0]      out_rank_r;
  logic [7:0]      out_fill_r;
  entry_t          out_ent_r;

  logic            gap_short, stop_req, thin_hit, vend_bad, read_hit, full, key_first;
  logic [XW-1:0]   evict_x, total_x;
  logic [CW-1:0]   k_eff;

  assign full      = (total_r >= Full);
  assign gap_short = (32'(time_r - last_r) < {16'd0, min_gap_ms});
  assign stop_req  = (counter_r > report_limit) || full;
  assign total_x   = XW'(total_r);
  assign evict_x   = XW'(evict_count);
  assign thin_hit  = (total_x > XW'(thin_above)) && counter_r[0];
  assign vend_bad  = (mac_r[47:24] != vendor_prefix);
  assign read_hit  = ({{XW-7{1'b0}}, idx_r} < total_x);
  assign k_eff     = (evict_x >= total_x) ? total_r : CW'(evict_count);
  assign key_first = goes_before(key_r, mem_rdata, by_age_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_DECIDE;
      S_DECIDE: begin
        unique case (func_r)
          FUNC_REPORT: begin
            if (gap_short || stop_req || thin_hit || vend_bad) state_nxt = S_FINISH;
            else state_nxt = S_SRCH_RD;
          end
          FUNC_RESCAN: state_nxt = full ? S_KEY_RD : S_FINISH;
          FUNC_READ:   state_nxt = read_hit ? S_READ_RD : S_FINISH;
          default:     state_nxt = S_FINISH;
        endcase
      end
      S_SRCH_RD:  state_nxt = (i_r == total_r) ? S_INS_WR : S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = (mem_rdata.mac == mac_r) ? S_KEY_RD : S_SRCH_RD;
      S_INS_WR:   state_nxt = S_KEY_RD;
      S_KEY_RD: begin
        if (i_r < total_r) state_nxt = S_KEY_LD;
        else if (by_age_r) state_nxt = (k_eff == '0) ? S_FINISH : S_MOVE_RD;
        else state_nxt = S_FINISH;
      end
      S_KEY_LD:   state_nxt = S_SORT_RD;
      S_SORT_RD:  state_nxt = (j_r == '0) ? S_KEY_RD : S_SORT_CMP;
      S_SORT_CMP: state_nxt = key_first ? S_SORT_RD : S_KEY_RD;
      S_MOVE_RD:  state_nxt = (i_r == rest_r) ? S_FINISH : S_MOVE_WR;
      S_MOVE_WR:  state_nxt = S_MOVE_RD;
      S_READ_RD:  state_nxt = S_READ_OUT;
      S_READ_OUT: state_nxt = S_FINISH;
      S_FINISH:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(j_r);
    mem_wdata = key_r;
    mem_raddr = AW'(i_r);
    unique case (state_r)
      S_SRCH_CMP: begin
        mem_we    = (mem_rdata.mac == mac_r);
        mem_waddr = AW'(i_r);
        mem_wdata = '{mac: mac_r, rssi: rssi_r, seen: time_r};
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(total_r);
        mem_wdata = '{mac: mac_r, rssi: rssi_r, seen: time_r};
      end
      S_SORT_RD: begin
        mem_raddr = AW'(j_r - 1'b1);
        mem_we    = (j_r == '0);
      end
      S_SORT_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = key_first ? mem_rdata : key_r;
      end
      S_MOVE_RD:  mem_raddr = AW'(i_r + k_r);
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_r);
        mem_wdata = mem_rdata;
      end
      S_READ_RD:  mem_raddr = AW'(idx_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      counter_r    <= '0;
      last_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_FINISH);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (func_t'(in_func) == FUNC_REPORT && counter_r != 16'hFFFF) begin
              counter_r <= counter_r + 16'd1;
            end else if (func_t'(in_func) == FUNC_RESCAN) begin
              counter_r <= '0;
            end
          end
        end
        S_DECIDE: begin
          if (func_r == FUNC_REPORT && !gap_short) last_r <= time_r;
        end
        S_INS_WR: total_r <= total_r + 1'b1;
        S_MOVE_RD: begin
          if (i_r == rest_r) total_r <= rest_r;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        func_r <= func_t'(in_func);
        mac_r  <= in_mac;
        rssi_r <= in_rssi;
        time_r <= in_time_ms;
        idx_r  <= in_index;
        ent_r  <= '0;
      end
      S_DECIDE: begin
        // A rescan starts the age sort at the second entry right away.
        i_r      <= (func_r == FUNC_RESCAN) ? CW'(1) : '0;
        by_age_r <= (func_r == FUNC_RESCAN);
        track_r  <= Full;
        unique case (func_r)
          FUNC_REPORT: begin
            if (gap_short) status_r <= ST_TOO_SOON;
            else if (stop_req) status_r <= ST_STOP_SCAN;
            else if (thin_hit) status_r <= ST_THINNED;
            else if (vend_bad) status_r <= ST_WRONG_VEND;
          end
          FUNC_RESCAN: status_r <= ST_RESCAN;
          FUNC_READ: status_r <= read_hit ? ST_READ_OK : ST_READ_EMPTY;
          default:   status_r <= ST_READ_EMPTY;
        endcase
      end
      S_SRCH_CMP: begin
        if (mem_rdata.mac == mac_r) begin
          status_r <= ST_UPDATED;
          track_r  <= i_r;
          i_r      <= CW'(1);
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      S_INS_WR: begin
        status_r <= ST_INSERTED;
        track_r  <= total_r;
        i_r      <= CW'(1);
      end
      S_KEY_RD: begin
        if (!(i_r < total_r)) begin
          k_r    <= k_eff;
          rest_r <= total_r - k_eff;
          i_r    <= '0;
        end
      end
      S_KEY_LD: begin
        key_r     <= mem_rdata;
        key_trk_r <= (track_r == i_r);
        j_r       <= i_r;
      end
      S_SORT_RD: begin
        if (j_r == '0) begin
          if (key_trk_r) track_r <= '0;
          i_r <= i_r + 1'b1;
        end
      end
      S_SORT_CMP: begin
        if (key_first) begin
          if (!key_trk_r && track_r == j_r - 1'b1) track_r <= j_r;
          j_r <= j_r - 1'b1;
        end else begin
          if (key_trk_r) track_r <= j_r;
          i_r <= i_r + 1'b1;
        end
      end
      S_MOVE_WR:  i_r <= i_r + 1'b1;
      S_READ_OUT: ent_r <= mem_rdata;
      S_FINISH: begin
        out_status_r <= status_r;
        out_fill_r   <= 8'(total_r);
        out_ent_r    <= ent_r;
        if (status_r == ST_UPDATED || status_r == ST_INSERTED) out_rank_r <= 7'(track_r);
        else if (func_r == FUNC_READ) out_rank_r <= idx_r;
        else out_rank_r <= '0;
      end
      default: ;
    endcase
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_rank       = out_rank_r;
  assign out_fill       = out_fill_r;
  assign out_entry_mac  = out_ent_r.mac;
  assign out_entry_rssi = out_ent_r.rssi;
  assign out_entry_seen = out_ent_r.seen;
endmodule
`default_nettype wire

// ===== design/vendor_filtered_signal_ranked_table_unit.sv =====
// Top level of the vendor-filtered signal-ranked device table.
`default_nettype none
// An item is taken when start is high while busy is low; busy stays high until
// its single result has been produced, and that result is shown on the out_
// ports for exactly one cycle, marked by out_strobe. The receiver cannot stall
// the block, so it must take every result in the cycle it appears. All table
// entries live in one memory with a registered read and one write port, and
// every step of a search, a sort or a compaction costs one memory read
// followed by a compare or write. A kept report searches the table, writes
// its entry, then runs an insertion sort pass by signal; with f the fill, a
// table left in age order by a rescan can need up to f*f/2 moves on the
// following report. A rescan on a full table runs the age sort the same way,
// then drops the evict_count oldest entries (all, if evict_count is not
// below the fill) and moves the rest to the front. Configuration writes must
// be made while busy is low.
module vendor_filtered_signal_ranked_table_unit #(
  parameter int unsigned TABLE_DEPTH = vfsrt_pkg::TableDepthDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_func,
  input  wire logic [47:0]       in_mac,
  input  wire logic signed [7:0] in_rssi,
  input  wire logic [31:0]       in_time_ms,
  input  wire logic [6:0]        in_index,
  output logic                   out_strobe,
  output logic [3:0]             out_status,
  output logic [6:0]             out_rank,
  output logic [7:0]             out_fill,
  output logic [47:0]            out_entry_mac,
  output logic signed [7:0]      out_entry_rssi,
  output logic [31:0]            out_entry_seen,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [23:0]       cfg_wdata
);
  import vfsrt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [23:0] vendor_prefix_r;
  logic [15:0] min_gap_r;
  logic [15:0] report_limit_r;
  logic [7:0]  thin_above_r;
  logic [7:0]  evict_count_r;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vendor_prefix_r <= VendorPrefixRst;
      min_gap_r       <= MinGapRst;
      report_limit_r  <= ReportLimitRst;
      thin_above_r    <= ThinAboveRst;
      evict_count_r   <= EvictCountRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_VENDOR_PREFIX: vendor_prefix_r <= cfg_wdata;
        REG_MIN_GAP:       min_gap_r       <= cfg_wdata[15:0];
        REG_REPORT_LIMIT:  report_limit_r  <= cfg_wdata[15:0];
        REG_THIN_ABOVE:    thin_above_r    <= cfg_wdata[7:0];
        REG_EVICT_COUNT:   evict_count_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  vfsrt_seq #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW),
    .CW(CW)
  ) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_mac(in_mac),
    .in_rssi(in_rssi),
    .in_time_ms(in_time_ms),
    .in_index(in_index),
    .vendor_prefix(vendor_prefix_r),
    .min_gap_ms(min_gap_r),
    .report_limit(report_limit_r),
    .thin_above(thin_above_r),
    .evict_count(evict_count_r),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_rank(out_rank),
    .out_fill(out_fill),
    .out_entry_mac(out_entry_mac),
    .out_entry_rssi(out_entry_rssi),
    .out_entry_seen(out_entry_seen)
  );

  vfsrt_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );
endmodule
`default_nettype wire

// ===== bench/vendor_filtered_signal_ranked_table_unit_tb.sv =====
// Self-checking testbench of the vendor-filtered signal-ranked device table.
`timescale 1ns / 1ps
module vendor_filtered_signal_ranked_table_unit_tb;
  import vfsrt_pkg::*;

  localparam int Depth = 128;
  // Cycles without any handshake before the run is declared hung. The slowest
  // single item is an age sort of a full table, well under this figure.
  localparam int HangLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = FUNC_NONE;
  logic [47:0] in_mac = '0;
  logic signed [7:0] in_rssi = '0;
  logic [31:0] in_time_ms = '0;
  logic [6:0] in_index = '0;
  logic out_strobe;
  logic [3:0] out_status;
  logic [6:0] out_rank;
  logic [7:0] out_fill;
  logic [47:0] out_entry_mac;
  logic signed [7:0] out_entry_rssi;
  logic [31:0] out_entry_seen;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  vendor_filtered_signal_ranked_table_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_mac(in_mac), .in_rssi(in_rssi),
    .in_time_ms(in_time_ms), .in_index(in_index),
    .out_strobe(out_strobe), .out_status(out_status), .out_rank(out_rank),
    .out_fill(out_fill), .out_entry_mac(out_entry_mac),
    .out_entry_rssi(out_entry_rssi), .out_entry_seen(out_entry_seen),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // One expected answer of the table.
  typedef struct {
    status_t status;
    logic [6:0] rank;
    logic [7:0] fill;
    logic [47:0] mac;
    logic signed [7:0] rssi;
    logic [31:0] seen;
  } answer_t;

  // Keeps its own copy of the table and predicts the answer to every item.
  class table_scoreboard;
    logic [23:0] prefix = VendorPrefixRst;
    logic [15:0] gap = MinGapRst;
    logic [15:0] limit = ReportLimitRst;
    logic [7:0] thin = ThinAboveRst;
    logic [7:0] evict = EvictCountRst;
    logic [47:0] t_mac[Depth];
    logic signed [7:0] t_rssi[Depth];
    logic [31:0] t_seen[Depth];
    int total = 0;
    int counter = 0;
    logic [31:0] last_pass = '0;
    answer_t pending[$];
    int errors = 0;

    function void set_reg(reg_idx_t idx, logic [23:0] val);
      case (idx)
        REG_VENDOR_PREFIX: prefix = val;
        REG_MIN_GAP: gap = val[15:0];
        REG_REPORT_LIMIT: limit = val[15:0];
        REG_THIN_ABOVE: thin = val[7:0];
        REG_EVICT_COUNT: evict = val[7:0];
        default: ;
      endcase
    endfunction

    function bit ahead(int x, int y, bit by_age);
      if (by_age) begin
        if (t_seen[x] != t_seen[y]) return t_seen[x] < t_seen[y];
        return t_rssi[x] < t_rssi[y];
      end
      return t_rssi[x] > t_rssi[y];
    endfunction

    // Stable insertion sort; the tracked position follows one entry.
    function void reorder(bit by_age, ref int track);
      logic [47:0] m;
      logic signed [7:0] r;
      logic [31:0] s;
      for (int i = 1; i < total; i++) begin
        for (int j = i; j > 0 && ahead(j, j - 1, by_age); j--) begin
          m = t_mac[j]; r = t_rssi[j]; s = t_seen[j];
          t_mac[j] = t_mac[j-1]; t_rssi[j] = t_rssi[j-1]; t_seen[j] = t_seen[j-1];
          t_mac[j-1] = m; t_rssi[j-1] = r; t_seen[j-1] = s;
          if (track == j) track = j - 1;
          else if (track == j - 1) track = j;
        end
      end
    endfunction

    function status_t take_report(logic [47:0] mac, logic signed [7:0] rssi,
                                  logic [31:0] now, ref int pos);
      logic [31:0] since;
      since = now - last_pass;
      if (counter < 65535) counter++;
      if (since < {16'd0, gap}) return ST_TOO_SOON;
      last_pass = now;
      if (counter > limit || total >= Depth) return ST_STOP_SCAN;
      if (total > thin && counter[0]) return ST_THINNED;
      if (mac[47:24] != prefix) return ST_WRONG_VEND;
      for (int i = 0; i < total; i++) begin
        if (t_mac[i] == mac) begin
          t_rssi[i] = rssi;
          t_seen[i] = now;
          pos = i;
          reorder(1'b0, pos);
          return ST_UPDATED;
        end
      end
      pos = total;
      t_mac[pos] = mac; t_rssi[pos] = rssi; t_seen[pos] = now;
      total++;
      reorder(1'b0, pos);
      return ST_INSERTED;
    endfunction

    function void take_rescan();
      int k;
      int none;
      none = Depth;
      counter = 0;
      if (total < Depth) return;
      reorder(1'b1, none);
      k = (evict > total) ? total : evict;
      for (int i = 0; i + k < total; i++) begin
        t_mac[i] = t_mac[i+k]; t_rssi[i] = t_rssi[i+k]; t_seen[i] = t_seen[i+k];
      end
      total -= k;
    endfunction

    // Called for every item at the edge that accepts it.
    function void note_item(logic [1:0] func, logic [47:0] mac, logic signed [7:0] rssi,
                            logic [31:0] now, logic [6:0] idx);
      answer_t a;
      int pos;
      pos = 0;
      a.mac = '0; a.rssi = '0; a.seen = '0; a.rank = '0;
      if (func == FUNC_REPORT) begin
        a.status = take_report(mac, rssi, now, pos);
        if (a.status == ST_UPDATED || a.status == ST_INSERTED) a.rank = pos[6:0];
      end else if (func == FUNC_RESCAN) begin
        take_rescan();
        a.status = ST_RESCAN;
      end else if (func == FUNC_READ && idx < total) begin
        a.status = ST_READ_OK;
        a.rank = idx;
        a.mac = t_mac[idx]; a.rssi = t_rssi[idx]; a.seen = t_seen[idx];
      end else begin
        a.status = ST_READ_EMPTY;
        if (func == FUNC_READ) a.rank = idx;
      end
      a.fill = total[7:0];
      pending.insert(pending.size(), a);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [3:0] st, logic [6:0] rk, logic [7:0] fl, logic [47:0] m,
                      logic signed [7:0] r, logic [31:0] s);
      answer_t a;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result status", st, 0);
        return;
      end
      a = pending.pop_front();
      if (st != a.status) report_mismatch("status", st, a.status);
      if (rk != a.rank) report_mismatch("rank", rk, a.rank);
      if (fl != a.fill) report_mismatch("fill", fl, a.fill);
      if (m != a.mac) report_mismatch("entry_mac", m, a.mac);
      if (r != a.rssi) report_mismatch("entry_rssi", r, a.rssi);
      if (s != a.seen) report_mismatch("entry_seen", s, a.seen);
    endtask
  endclass

  table_scoreboard sb = new();
  logic [31:0] clock_ms = 32'd1000;   // running time stamp of generated reports
  logic [23:0] mac_pool[32];          // low address halves that recur, so updates happen
  int quiet_cycles = 0;

  // Every result is taken in the cycle it is shown; the block cannot be stalled.
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_status, out_rank, out_fill, out_entry_mac, out_entry_rssi,
                      out_entry_seen);
  end

  // Watchdog: any accepted item or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offers one item after the given number of idle cycles and returns at the
  // edge that accepts it. Start is left high so a back-to-back item follows.
  task send_item(logic [1:0] func, logic [47:0] mac, logic signed [7:0] rssi,
                 logic [31:0] now, logic [6:0] idx, int idle);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func; in_mac <= mac; in_rssi <= rssi;
    in_time_ms <= now; in_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(func, mac, rssi, now, idx);
  endtask

  // Holds the sender back until every outstanding result has come.
  task drain();
    @(posedge clk);
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the write port is then left quiet before the task returns.
  task write_reg(reg_idx_t idx, logic [23:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function int pick_idle(bit burst);
    return burst ? 0 : $urandom_range(0, 3);
  endfunction

  // Report from a vendor device, mostly out of the recurring pool.
  task vendor_report(int idle);
    logic [23:0] low;
    low = ($urandom_range(0, 3) == 0) ? 24'($urandom) : mac_pool[$urandom_range(0, 31)];
    clock_ms += $urandom_range(0, 2 * sb.gap + 4);
    send_item(FUNC_REPORT, {sb.prefix, low}, 8'($urandom), clock_ms, 7'd0, idle);
  endtask

  // Mixed traffic: mostly well-formed vendor reports and reads of held ranks,
  // the rest foreign addresses, rescans, reads out of range and unused codes.
  task mixed_traffic(int count);
    int sel;
    bit burst;
    burst = 1'b0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 15) == 0) burst = ~burst;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        vendor_report(pick_idle(burst));
      end else if (sel < 65) begin
        clock_ms += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 200);
        send_item(FUNC_REPORT, {16'($urandom), 32'($urandom)}, 8'($urandom), clock_ms,
                  7'd0, pick_idle(burst));
      end else if (sel < 70) begin
        send_item(FUNC_RESCAN, {16'($urandom), 32'($urandom)}, 8'($urandom), $urandom,
                  7'($urandom), pick_idle(burst));
      end else if (sel < 92) begin
        send_item(FUNC_READ, {16'($urandom), 32'($urandom)}, 8'($urandom), $urandom,
                  (sb.total > 0 && sel < 86) ? 7'($urandom_range(0, sb.total - 1))
                                             : 7'($urandom),
                  pick_idle(burst));
      end else begin
        send_item(FUNC_NONE, {16'($urandom), 32'($urandom)}, 8'($urandom), $urandom,
                  7'($urandom), pick_idle(burst));
      end
    end
  endtask

  // Inserts fresh vendor addresses until the table holds every slot. Some
  // reports reuse a time stamp so the age sort meets equal times.
  task fill_table();
    while (sb.total < Depth) begin
      if ($urandom_range(0, 2) != 0) clock_ms += $urandom_range(1, 40);
      send_item(FUNC_REPORT, {sb.prefix, 24'($urandom)}, 8'($urandom), clock_ms, 7'd0,
                $urandom_range(0, 3));
    end
  endtask

  initial begin
    foreach (mac_pool[i]) mac_pool[i] = 24'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset settings.
    send_item(FUNC_RESCAN, '0, '0, '0, '0, 0);                       // rescan, empty table
    send_item(FUNC_READ, '0, '0, '0, 7'd0, 1);                       // read of an empty table
    send_item(FUNC_READ, '1, '1, '1, 7'd127, 0);
    send_item(FUNC_NONE, '1, '1, '1, 7'd127, 2);                     // unused function code
    send_item(FUNC_REPORT, {24'h0025DF, 24'h000001}, 8'sd10, 32'd10, 7'd0, 0); // too soon
    send_item(FUNC_REPORT, 48'h0, -8'sd128, 32'd100, 7'd0, 0);      // foreign, lowest mac
    send_item(FUNC_REPORT, '1, 8'sd127, 32'd200, 7'd0, 3);          // foreign, all ones
    send_item(FUNC_REPORT, {24'h0025DF, 24'h000000}, -8'sd128, 32'd300, 7'd0, 0);
    send_item(FUNC_REPORT, {24'h0025DF, 24'hFFFFFF}, 8'sd127, 32'd400, 7'd0, 0);
    send_item(FUNC_REPORT, {24'h0025DF, 24'h123456}, 8'sd0, 32'd500, 7'd0, 1);
    send_item(FUNC_REPORT, {24'h0025DF, 24'h000000}, 8'sd100, 32'd600, 7'd0, 0); // update
    send_item(FUNC_REPORT, {24'h0025DF, 24'h123456}, 8'sd100, 32'd700, 7'd0, 0); // tie
    send_item(FUNC_READ, '0, '0, '0, 7'd0, 0);
    send_item(FUNC_READ, '0, '0, '0, 7'd1, 0);
    send_item(FUNC_READ, '0, '0, '0, 7'd2, 2);
    send_item(FUNC_READ, '0, '0, '0, 7'd3, 0);                       // just past the fill
    send_item(FUNC_REPORT, {24'h0025DF, 24'h777777}, 8'sd5, 32'hFFFF_FFF0, 7'd0, 0);
    send_item(FUNC_REPORT, {24'h0025DF, 24'h888888}, 8'sd6, 32'd10, 7'd0, 0); // wrap, too soon
    send_item(FUNC_REPORT, {24'h0025DF, 24'h888888}, 8'sd6, 32'hFFFF_FFFF, 7'd0, 0);
    clock_ms = 32'd100;
    drain();

    // Every register written, at its top or bottom value where that is useful.
    write_reg(REG_VENDOR_PREFIX, 24'hFFFFFF);
    write_reg(REG_MIN_GAP, 24'd0);
    write_reg(REG_REPORT_LIMIT, 24'd65535);
    write_reg(REG_THIN_ABOVE, 24'd128);
    write_reg(REG_EVICT_COUNT, 24'd0);
    mixed_traffic(200);
    drain();

    // Full table: stop requests, then a rescan that only reorders by age.
    fill_table();
    mixed_traffic(40);
    send_item(FUNC_RESCAN, '0, '0, '0, '0, 0);
    for (int i = 0; i < 20; i++)
      send_item(FUNC_READ, '0, '0, '0, 7'($urandom), $urandom_range(0, 3));
    drain();

    // Ordinary eviction, then thinning of odd counts on a well-filled table.
    write_reg(REG_EVICT_COUNT, 24'd25);
    send_item(FUNC_RESCAN, '0, '0, '0, '0, 0);
    drain();
    write_reg(REG_THIN_ABOVE, 24'd0);
    mixed_traffic(100);
    drain();

    // Refill and clear the whole table with the largest eviction.
    write_reg(REG_THIN_ABOVE, 24'd128);
    fill_table();
    drain();
    write_reg(REG_EVICT_COUNT, 24'd128);
    send_item(FUNC_RESCAN, '0, '0, '0, '0, 0);
    drain();

    // Zero prefix and the widest gap: most reports are too soon.
    write_reg(REG_VENDOR_PREFIX, 24'h000000);
    write_reg(REG_MIN_GAP, 24'd65535);
    mixed_traffic(100);
    drain();

    // Zero report limit: every passing report asks for a scan stop.
    write_reg(REG_MIN_GAP, 24'd3);
    write_reg(REG_REPORT_LIMIT, 24'd0);
    mixed_traffic(60);
    drain();

    // Back near the reset settings for a long stretch of mixed traffic.
    write_reg(REG_VENDOR_PREFIX, VendorPrefixRst);
    write_reg(REG_MIN_GAP, 24'd20);
    write_reg(REG_REPORT_LIMIT, ReportLimitRst);
    write_reg(REG_THIN_ABOVE, 24'd40);
    write_reg(REG_EVICT_COUNT, EvictCountRst);
    mixed_traffic(300);
    drain();

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
